// ===== hw/rtl/ifdc_pkg.sv =====
// ----------------------------------------------------------------------------
// ifdc_pkg
// Shared types and codes for the int/float/double conversion unit.
// ----------------------------------------------------------------------------
`default_nettype none
package ifdc_pkg;

    typedef enum logic [1:0] {
        CMD_I2F   = 2'd0,
        CMD_F2I   = 2'd1,
        CMD_F2D   = 2'd2,
        CMD_SPARE = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] source_word;
    } ifdc_in_t;

    typedef struct packed {
        logic [31:0] result_low;
        logic [31:0] result_high;
        logic        second_write;
        logic        invalid;
    } ifdc_out_t;

    localparam logic [31:0] INT_MIN_WORD = 32'h8000_0000;

    // Position of the leading one (0 for zero input).
    function automatic logic [4:0] lead_one(input logic [31:0] v);
        logic [4:0] p;
        p = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (v[i])
                p = 5'(i);
        end
        return p;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/int_float_double_converter.sv =====
// ----------------------------------------------------------------------------
// int_float_double_converter
// int32 -> binary32 (RNE), binary32 -> int32 (truncate), binary32 -> binary64.
// ----------------------------------------------------------------------------
// Channel   Signals               Handshake
// input     start, busy, in_beat  accepted when start && !busy
// output    done, out_beat        one-cycle strobe, no backpressure
//
// One beat per cycle. Each command is converted by one combinational pass
// between the input register and the result register: done and the result
// beat both come from the result register and are loaded together.
// busy is always low; the receiver cannot stall.
// Reset clears the valid bits of both stages.
`default_nettype none
module int_float_double_converter (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   start,
    output logic                  busy,
    input  ifdc_pkg::ifdc_in_t    in_beat,
    output logic                  done,
    output ifdc_pkg::ifdc_out_t   out_beat
);
    import ifdc_pkg::*;

    logic      in_vld_reg;
    ifdc_in_t  in_reg;
    logic      out_vld_reg;
    ifdc_out_t out_reg;
    ifdc_out_t res_next;

    assign busy     = 1'b0;
    assign done     = out_vld_reg;
    assign out_beat = out_reg;

    // Valid pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= start && !busy;
            out_vld_reg <= in_vld_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (start && !busy)
            in_reg <= in_beat;
        if (in_vld_reg)
            out_reg <= res_next;
    end

    // Conversion datapath
    logic [31:0] w;
    logic        sgn;
    logic [7:0]  e;
    logic [22:0] frac;
    // int -> float
    logic [31:0] mag;
    logic [4:0]  p;
    logic [31:0] norm;
    logic [23:0] keep;
    logic [7:0]  low8;
    logic        rnd;
    logic [31:0] i2f;
    // float -> int
    logic [31:0] m32;
    logic [31:0] f2i_mag;
    logic [4:0]  ue;
    // float -> double
    logic [4:0]  fp;
    logic [10:0] e64;
    logic [22:0] f64;
    logic [22:0] fsh;

    always_comb
    begin
        w    = in_reg.source_word;
        sgn  = w[31];
        e    = w[30:23];
        frac = w[22:0];

        // int to float: normalize so the leading one sits at bit 31
        mag  = sgn ? (32'd0 - w) : w;
        p    = lead_one(mag);
        norm = mag << (5'd31 - p);
        keep = norm[31:8];
        low8 = norm[7:0];
        rnd  = low8[7] && ((low8[6:0] != 7'd0) || keep[0]);
        i2f  = {sgn, 31'd0} + (({24'd0, 3'd0, p} + 32'd126) << 23)
               + {8'd0, keep} + {31'd0, rnd};
        if (mag == 32'd0)
            i2f = 32'd0;

        // float to int (shift only used for unbiased exponents 0..30)
        m32     = {8'd0, 1'b1, frac};
        ue      = 5'(e - 8'd127);
        f2i_mag = (ue >= 5'd23) ? (m32 << (ue - 5'd23)) : (m32 >> (5'd23 - ue));

        // float to double
        fp  = lead_one({9'd0, frac});
        fsh = frac << (5'd23 - fp);
        e64 = {3'd0, e} + 11'd896;
        f64 = frac;
        if (e == 8'hFF)
        begin
            e64 = 11'h7FF;
            if (frac != 23'd0)
                f64 = frac | 23'h40_0000;
        end
        else if (e == 8'd0)
        begin
            e64 = 11'd874 + {6'd0, fp};
            f64 = fsh;
        end

        res_next = '0;
        unique case (cmd_t'(in_reg.cmd))
            CMD_I2F:
                res_next.result_low = i2f;
            CMD_F2I:
            begin
                if (e == 8'hFF)
                begin
                    res_next.result_low = INT_MIN_WORD;
                    res_next.invalid    = 1'b1;
                end
                else if (e < 8'd127)
                    res_next.result_low = 32'd0;
                else if (e >= 8'd158)
                begin
                    res_next.result_low = INT_MIN_WORD;
                    res_next.invalid    = !(sgn && e == 8'd158 && frac == 23'd0);
                end
                else
                    res_next.result_low = sgn ? (32'd0 - f2i_mag) : f2i_mag;
            end
            CMD_F2D:
            begin
                res_next.second_write = 1'b1;
                if (e == 8'd0 && frac == 23'd0)
                    res_next.result_high = {sgn, 31'd0};
                else
                begin
                    res_next.result_high = {sgn, e64, f64[22:3]};
                    res_next.result_low  = {f64[2:0], 29'd0};
                end
            end
            default:
                res_next = '0;
        endcase
    end

    // Checks
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg |=> done)
        else $error("result strobe missing");
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(in_vld_reg))
        else $error("result strobe without beat");
    a_second_f2d: assert property (@(posedge clk) disable iff (!rst_n)
        done && out_beat.second_write |-> !out_beat.invalid)
        else $error("second write with invalid flag");

endmodule
`default_nettype wire

// ===== test/int_float_double_converter_tb.sv =====
// ----------------------------------------------------------------------------
// int_float_double_converter_tb
// Drives int/float/double conversion commands into the converter and checks
// every result beat against a bit-level conversion model kept in the bench.
// ----------------------------------------------------------------------------
`default_nettype none
module int_float_double_converter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ifdc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    // Conversion model and queue of pending results
    class conv_scoreboard;
        ifdc_out_t pending[$];
        int        errors;

        function new();
            errors = 0;
        endfunction

        static function int top_bit(logic [31:0] v);
            int p;
            p = 0;
            for (int i = 0; i < 32; i++)
            begin
                if (v[i])
                    p = i;
            end
            return p;
        endfunction

        static function logic [31:0] int_to_single(logic [31:0] w);
            logic [31:0] mag, keep, rem, half;
            int p, sh;
            mag = w[31] ? -w : w;
            if (mag == 0)
                return 32'd0;
            p = top_bit(mag);
            if (p <= 23)
                keep = mag << (23 - p);
            else
            begin
                sh = p - 23;
                rem = mag & ((32'd1 << sh) - 1);
                half = 32'd1 << (sh - 1);
                keep = mag >> sh;
                if (rem > half || (rem == half && keep[0]))
                    keep++;
            end
            // hidden bit in keep; a rounding carry lands in the exponent
            return {w[31], 31'd0} | (((32'(126 + p)) << 23) + keep);
        endfunction

        function void note_input(ifdc_in_t b);
            ifdc_out_t r;
            logic [7:0]  e;
            logic [22:0] fr;
            logic [31:0] m, mag;
            logic [10:0] e64;
            int ue, p;
            r = '0;
            e = b.source_word[30:23];
            fr = b.source_word[22:0];
            case (cmd_t'(b.cmd))
                CMD_I2F:
                    r.result_low = int_to_single(b.source_word);
                CMD_F2I:
                begin
                    m = {9'd1, fr};
                    if (e == 8'hFF)
                    begin
                        r.invalid = 1'b1;
                        r.result_low = INT_MIN_WORD;
                    end
                    else if (e >= 127)
                    begin
                        ue = e - 127;
                        if (ue >= 31)
                        begin
                            r.result_low = INT_MIN_WORD;
                            r.invalid = !(b.source_word[31] && e == 158 && fr == 0);
                        end
                        else
                        begin
                            mag = (ue >= 23) ? (m << (ue - 23)) : (m >> (23 - ue));
                            r.result_low = b.source_word[31] ? -mag : mag;
                        end
                    end
                end
                CMD_F2D:
                begin
                    r.second_write = 1'b1;
                    if (e == 0 && fr == 0)
                        r.result_high = {b.source_word[31], 31'd0};
                    else
                    begin
                        if (e == 8'hFF)
                        begin
                            if (fr != 0)
                                fr[22] = 1'b1;
                            e64 = 11'h7FF;
                        end
                        else if (e == 0)
                        begin
                            p = top_bit({9'd0, fr});
                            e64 = 11'(874 + p);
                            fr = 23'({9'd0, fr} << (23 - p));
                        end
                        else
                            e64 = 11'(e) + 11'd896;
                        r.result_high = {b.source_word[31], e64, fr[22:3]};
                        r.result_low = {fr[2:0], 29'd0};
                    end
                end
                default: ;
            endcase
            pending.push_back(r);
        endfunction

        function void check_result(ifdc_out_t a);
            ifdc_out_t x;
            if (pending.size() == 0)
            begin
                $error("unexpected result beat");
                errors++;
                return;
            end
            x = pending.pop_front();
            if (a.result_low !== x.result_low)
            begin
                $error("result_low exp %h got %h", x.result_low, a.result_low);
                errors++;
            end
            if (a.result_high !== x.result_high)
            begin
                $error("result_high exp %h got %h", x.result_high, a.result_high);
                errors++;
            end
            if (a.second_write !== x.second_write)
            begin
                $error("second_write exp %b got %b", x.second_write, a.second_write);
                errors++;
            end
            if (a.invalid !== x.invalid)
            begin
                $error("invalid exp %b got %b", x.invalid, a.invalid);
                errors++;
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    ifdc_in_t  in_beat;
    logic      done;
    ifdc_out_t out_beat;

    conv_scoreboard board;
    int             idle_cycles;

    int_float_double_converter dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .in_beat (in_beat),
        .done    (done),
        .out_beat(out_beat)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Accepted input and result beats, sampled at the edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                board.note_input(in_beat);
            if (done)
                board.check_result(out_beat);
            idle_cycles <= (start && !busy) || done ? 0 : idle_cycles + 1;
        end
    end

    // Watchdog on cycles with no traffic
    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // One command beat; gap drawn before, held until accepted
    task automatic send_cmd(cmd_t c, logic [31:0] w, bit use_gap);
        int gap;
        gap = use_gap ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        in_beat <= '{cmd: c, source_word: w};
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Random binary32 pattern, biased toward interesting exponents
    function automatic logic [31:0] rand_single();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 5))
            0: w[30:23] = 8'h00;
            1: w[30:23] = 8'hFF;
            2: w[30:23] = 8'($urandom_range(120, 165));
            default: ;
        endcase
        if ($urandom_range(0, 7) == 0)
            w[22:0] = 23'd0;
        return w;
    endfunction

    initial
    begin
        logic [31:0] directed_words[$];
        cmd_t        c;
        bit          quiet;
        int          waited;
        board = new();
        idle_cycles = 0;
        rst_n = 1'b0;
        start = 1'b0;
        in_beat = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, range edges, ties, NaN, subnormal, spare command
        directed_words = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                           32'h0100_0001, 32'h0100_0003, 32'h4F00_0000, 32'hCF00_0000,
                           32'hCF00_0001, 32'h7F80_0000, 32'h7FC0_0001, 32'hFF80_0001,
                           32'h0000_0001, 32'h807F_FFFF, 32'h3F7F_FFFF, 32'hBF80_0000,
                           32'h8000_0000, 32'h4B7F_FFFF};
        foreach (directed_words[i])
        begin
            send_cmd(CMD_I2F, directed_words[i], 1'b0);
            send_cmd(CMD_F2I, directed_words[i], 1'b0);
            send_cmd(CMD_F2D, directed_words[i], 1'b0);
        end
        send_cmd(CMD_SPARE, 32'hFFFF_FFFF, 1'b0);

        // Random part, with back-to-back stretches
        quiet = 1'b0;
        for (int n = 0; n < 1900; n++)
        begin
            if (n % 200 == 0)
                quiet = $urandom_range(0, 2) == 0;
            c = cmd_t'($urandom_range(0, 15) == 0 ? 3 : $urandom_range(0, 2));
            send_cmd(c, (c == CMD_I2F && $urandom_range(0, 1)) ? $urandom : rand_single(),
                     !quiet);
        end
        start <= 1'b0;

        // Drain
        waited = 0;
        while (board.pending.size() != 0 && waited < 1000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (5) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire
